FILE: rtl/ugti_pkg.sv
// Shared types and constants for the uniform grid table interpolator.
package ugti_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_ORIGIN     = 3'd0,
    REG_INVERSE_SPACING = 3'd1,
    REG_TABLE_LENGTH    = 3'd2,
    REG_COLUMNS_USED    = 3'd3,
    REG_INTERP_MODE     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_NEAREST = 1'b0,
    MODE_LINEAR  = 1'b1
  } interp_mode_t;

  // Field widths
  localparam int unsigned POS_W    = 32;
  localparam int unsigned WIDX_W   = 10;
  localparam int unsigned WCOL_W   = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned NCOL_W   = 3;

  // One half in Q32.32
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  // Reset values of the configuration registers
  localparam logic [31:0]       RST_GRID_ORIGIN     = 32'd0;
  localparam logic [31:0]       RST_INVERSE_SPACING = 32'd65536;
  localparam logic [LEN_W-1:0]  RST_TABLE_LENGTH    = 11'd2;
  localparam logic [NCOL_W-1:0] RST_COLUMNS_USED    = 3'd1;

endpackage

FILE: rtl/uniform_grid_table_interpolator.sv
// Uniform grid table interpolator: sample table, position math and per-column blend.
// A query passes the stage registers in order, then the output register, before its first result beat is valid.
// Throughput: one write beat per cycle unless stalled; a query holds the serializer
// until its last column moves on, yielding one result beat per cycle unless stalled.
// Reset (rst_n low, synchronous) empties the pipeline and restores register defaults;
// the sample table is not cleared and holds garbage until written.
module uniform_grid_table_interpolator
  import ugti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COLUMNS     = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // position[31:0], write_index[41:32], write_column[43:42],
                                  // write_value[59:44], zero pad[63:60]
  input  logic [0:0]  in_tuser,   // cmd[0]

  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value[15:0], column[17:16], zero pad[23:18]
  output logic [0:0]  out_tuser,  // out_of_range[0]
  output logic        out_tlast,  // last column of the query

  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------------
  logic [31:0]       grid_origin_r;
  logic [31:0]       inverse_spacing_r;
  logic [LEN_W-1:0]  table_length_r;
  logic [NCOL_W-1:0] columns_used_r;
  interp_mode_t      interp_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_origin_r     <= RST_GRID_ORIGIN;
      inverse_spacing_r <= RST_INVERSE_SPACING;
      table_length_r    <= RST_TABLE_LENGTH;
      columns_used_r    <= RST_COLUMNS_USED;
      interp_mode_r     <= MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_ORIGIN:     grid_origin_r     <= cfg_data;
        REG_INVERSE_SPACING: inverse_spacing_r <= cfg_data;
        REG_TABLE_LENGTH:    table_length_r    <= cfg_data[LEN_W-1:0];
        REG_COLUMNS_USED:    columns_used_r    <= cfg_data[NCOL_W-1:0];
        REG_INTERP_MODE:     interp_mode_r     <= interp_mode_t'(cfg_data[0]);
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Effective table length: clamp to the physical depth
  logic [LEN_W-1:0] len_eff;
  assign len_eff = (32'(table_length_r) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : table_length_r;

  // Index of the last column answered: zero acts as one, too many acts as all
  logic [CIW-1:0] lastc_cfg;
  always_comb begin
    if (columns_used_r == '0) begin
      lastc_cfg = '0;
    end else if (32'(columns_used_r) > COLUMNS) begin
      lastc_cfg = CIW'(COLUMNS - 1);
    end else begin
      lastc_cfg = CIW'(columns_used_r - NCOL_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Ready chain, from the output register back to the input
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  cmd_t cmd1_r, cmd2_r, cmd3_r, cmd4_r;
  logic [CIW-1:0] cidx5_r, lastc5_r;

  logic out_rdy, s7_rdy, s6_rdy, s5_done, s5_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;

  assign out_rdy = !out_valid_r || out_tready;
  assign s7_rdy  = !v7_r || out_rdy;
  assign s6_rdy  = !v6_r || s7_rdy;
  // The serializer frees up once its last column moves on
  assign s5_done = v5_r && s6_rdy && (cidx5_r == lastc5_r);
  assign s5_rdy  = !v5_r || s5_done;
  // A write retires in stage 4 and never waits on the serializer
  assign s4_rdy  = !v4_r || (cmd4_r == CMD_WRITE) || s5_rdy;
  assign s3_rdy  = !v3_r || s4_rdy;
  assign s2_rdy  = !v2_r || s3_rdy;
  assign s1_rdy  = !v1_r || s2_rdy;
  assign in_tready = s1_rdy;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the input beat
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0]    pos1_r;
  logic [WIDX_W-1:0]          widx1_r, widx2_r, widx3_r, widx4_r;
  logic [WCOL_W-1:0]          wcol1_r, wcol2_r, wcol3_r, wcol4_r;
  logic signed [SAMPLE_W-1:0] wval1_r, wval2_r, wval3_r, wval4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_rdy) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      cmd1_r  <= cmd_t'(in_tuser[0]);
      pos1_r  <= $signed(in_tdata[31:0]);
      widx1_r <= in_tdata[41:32];
      wcol1_r <= in_tdata[43:42];
      wval1_r <= $signed(in_tdata[59:44]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: distance from the origin as sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [POS_W:0] delta;
  logic [POS_W-1:0]      mag2_nxt;
  logic [POS_W-1:0]      mag2_r;
  logic                  neg2_r;

  assign delta    = {pos1_r[POS_W-1], pos1_r} - {grid_origin_r[31], grid_origin_r};
  // |delta| stays below 2^32, so the magnitude fits in 32 bits
  assign mag2_nxt = delta[POS_W] ? POS_W'(-delta) : delta[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_rdy) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      cmd2_r  <= cmd1_r;
      mag2_r  <= mag2_nxt;
      neg2_r  <= delta[POS_W];
      widx2_r <= widx1_r;
      wcol2_r <= wcol1_r;
      wval2_r <= wval1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: |t| = |delta| * inverse_spacing in Q32.32
  // ---------------------------------------------------------------------------
  logic [63:0] p3_r;
  logic        neg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_rdy) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      cmd3_r  <= cmd2_r;
      p3_r    <= 64'(mag2_r) * 64'(inverse_spacing_r);
      neg3_r  <= neg2_r;
      widx3_r <= widx2_r;
      wcol3_r <= wcol2_r;
      wval3_r <= wval2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: row, fraction and range check; table access happens here
  // ---------------------------------------------------------------------------
  logic        neg_t;
  logic [31:0] ip3;
  logic [32:0] near_row;
  logic        lin_ok, near_ok, ok4_nxt;
  logic [AW-1:0] row4_nxt;

  // A zero product is never negative
  assign neg_t    = neg3_r && (p3_r != 64'd0);
  assign ip3      = p3_r[63:32];
  // round half up: floor(t + 1/2)
  assign near_row = {1'b0, ip3} + {32'd0, p3_r[31]};

  always_comb begin
    lin_ok = !neg_t && (len_eff >= LEN_W'(2)) && (ip3 <= 32'(len_eff - LEN_W'(2)));
    if (neg_t) begin
      near_ok = (p3_r <= HALF_Q32) && (len_eff != '0);
    end else begin
      near_ok = near_row < 33'(len_eff);
    end
    if (interp_mode_r == MODE_LINEAR) begin
      ok4_nxt  = lin_ok;
      row4_nxt = lin_ok ? AW'(ip3) : '0;
    end else begin
      ok4_nxt  = near_ok;
      row4_nxt = (near_ok && !neg_t) ? AW'(near_row) : '0;
    end
  end

  logic          ok4_r;
  logic [AW-1:0] row4_r;
  logic [31:0]   frac4_r;
  interp_mode_t  mode4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (s4_rdy) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      cmd4_r  <= cmd3_r;
      ok4_r   <= ok4_nxt;
      row4_r  <= row4_nxt;
      frac4_r <= p3_r[31:0];
      mode4_r <= interp_mode_r;
      widx4_r <= widx3_r;
      wcol4_r <= wcol3_r;
      wval4_r <= wval3_r;
    end
  end

  // Writes land in program order with the reads of the queries around them
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [AW-1:0] row4_p1;

  assign wr_en   = v4_r && (cmd4_r == CMD_WRITE) &&
                   (32'(widx4_r) < TABLE_DEPTH) && (32'(wcol4_r) < COLUMNS);
  assign waddr   = AW'(widx4_r);
  assign row4_p1 = row4_r + AW'(1);

  // One memory per column; read both neighbor rows whenever stage 5 can load
  logic [COLUMNS-1:0][SAMPLE_W-1:0] y0_s5;
  logic [COLUMNS-1:0][SAMPLE_W-1:0] y1_s5;

  for (genvar gc = 0; gc < COLUMNS; gc++) begin : g_col
    logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
    logic [SAMPLE_W-1:0] rd0_r, rd1_r;

    always_ff @(posedge clk) begin
      if (wr_en && (32'(wcol4_r) == gc)) begin
        mem[waddr] <= wval4_r;
      end
      if (s5_rdy) begin
        rd0_r <= mem[row4_r];
        rd1_r <= mem[row4_p1];
      end
    end

    assign y0_s5[gc] = rd0_r;
    assign y1_s5[gc] = rd1_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: column serializer, unless stalled one column per cycle
  // ---------------------------------------------------------------------------
  logic         ok5_r;
  logic [31:0]  frac5_r;
  interp_mode_t mode5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r     <= 1'b0;
      cidx5_r  <= '0;
      lastc5_r <= '0;
    end else if (s5_rdy) begin
      v5_r     <= v4_r && (cmd4_r == CMD_QUERY);
      cidx5_r  <= '0;
      lastc5_r <= lastc_cfg;
    end else if (v5_r && s6_rdy) begin
      cidx5_r <= cidx5_r + CIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy) begin
      ok5_r   <= ok4_r;
      frac5_r <= frac4_r;
      mode5_r <= mode4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: pick the column and form the slope
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] y0_sel, y1_sel;
  logic signed [SAMPLE_W:0]   diff6_nxt;

  assign y0_sel    = $signed(y0_s5[cidx5_r]);
  assign y1_sel    = $signed(y1_s5[cidx5_r]);
  assign diff6_nxt = {y1_sel[SAMPLE_W-1], y1_sel} - {y0_sel[SAMPLE_W-1], y0_sel};

  logic signed [SAMPLE_W:0]   diff6_r;
  logic signed [SAMPLE_W-1:0] y0_6_r;
  logic [31:0]                frac6_r;
  logic                       ok6_r, last6_r;
  interp_mode_t               mode6_r;
  logic [WCOL_W-1:0]          col6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (s6_rdy) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy) begin
      diff6_r <= diff6_nxt;
      y0_6_r  <= y0_sel;
      frac6_r <= frac5_r;
      ok6_r   <= ok5_r;
      mode6_r <= mode5_r;
      col6_r  <= WCOL_W'(cidx5_r);
      last6_r <= (cidx5_r == lastc5_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: slope times fraction
  // ---------------------------------------------------------------------------
  logic signed [49:0] prod_full;
  assign prod_full = diff6_r * $signed({1'b0, frac6_r});

  logic [47:0]                prod7_r;
  logic signed [SAMPLE_W-1:0] y0_7_r;
  logic                       ok7_r, last7_r;
  interp_mode_t               mode7_r;
  logic [WCOL_W-1:0]          col7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (s7_rdy) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_rdy) begin
      prod7_r <= prod_full[47:0];
      y0_7_r  <= y0_6_r;
      ok7_r   <= ok6_r;
      mode7_r <= mode6_r;
      col7_r  <= col6_r;
      last7_r <= last6_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: in linear mode add base and half, keep the integer part
  // ---------------------------------------------------------------------------
  logic [47:0]         blend_sum;
  logic [SAMPLE_W-1:0] value_nxt;

  // Only bits 47:32 survive, so modulo 2^48 arithmetic is exact for them
  assign blend_sum = {y0_7_r, 32'd0} + prod7_r + HALF_Q32[47:0];

  always_comb begin
    if (!ok7_r) begin
      value_nxt = '0;
    end else if (mode7_r == MODE_LINEAR) begin
      value_nxt = blend_sum[47:32];
    end else begin
      value_nxt = y0_7_r;
    end
  end

  logic [SAMPLE_W-1:0] value_r;
  logic [WCOL_W-1:0]   col_r;
  logic                oor_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      value_r <= value_nxt;
      col_r   <= col7_r;
      oor_r   <= !ok7_r;
      last_r  <= last7_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, col_r, value_r};
  assign out_tuser  = oor_r;
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  // The serializer never runs past the last column of its query
  a_cidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (cidx5_r <= lastc5_r))
    else $error("column index beyond last column");

  // After the last column leaves, the serializer is empty or restarts at column zero
  a_serializer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s5_done |=> (!v5_r || (cidx5_r == '0)))
    else $error("serializer did not restart");

  // A query waiting on the serializer keeps its row
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (cmd4_r == CMD_QUERY) && !s5_rdy) |=> (v4_r && $stable(row4_r)))
    else $error("stalled query lost or changed");

  // Out-of-range results carry a zero value
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[15:0] == '0))
    else $error("out-of-range result with nonzero value");

  // Writes never reach the table while a query waits in stage 4
  a_no_wr_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cmd4_r == CMD_WRITE) && s4_rdy)
    else $error("table write without a retiring write beat");
`endif

endmodule

FILE: tb/tb_uniform_grid_table_interpolator.sv
// Self-checking testbench for the uniform grid table interpolator (stream in, stream out).
`timescale 1ns / 1ps

module tb_uniform_grid_table_interpolator;
  import ugti_pkg::*;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned N_COLS = 4;
  // Low rows loaded in every column; random table lengths stay within them.
  localparam int unsigned LOAD_ROWS = 16;
  // Longest run of cycles with no beat on any channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Length of the output hold-off that forces the block to fill up.
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  column;
    logic        out_of_range;
    logic        last;
  } interp_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the block's state and registers
  logic signed [15:0] grid_samples [N_COLS][DEPTH];
  logic [31:0]        origin_q = RST_GRID_ORIGIN;
  logic [31:0]        inv_q    = RST_INVERSE_SPACING;
  logic [LEN_W-1:0]   len_q    = RST_TABLE_LENGTH;
  logic [NCOL_W-1:0]  cols_q   = RST_COLUMNS_USED;
  interp_mode_t       mode_q   = MODE_LINEAR;

  interp_result_t predicted_samples [$];
  int unsigned    errors    = 0;
  bit             idle_on   = 1'b1;
  int unsigned    sink_gap  = 0;
  int unsigned    hold_left = 0;

  uniform_grid_table_interpolator #(
    .TABLE_DEPTH (DEPTH),
    .COLUMNS     (N_COLS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wire any_beat = (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready);

  // Effective table length and column count after clamping
  function automatic int unsigned eff_len();
    return (len_q > DEPTH) ? DEPTH : int'(len_q);
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_q == 0) return 1;
    if (cols_q > N_COLS) return N_COLS;
    return cols_q;
  endfunction

  // Work out the result beats of one query and queue them in column order.
  function automatic void interpolate_query(input logic [31:0] pos);
    int             pos_s, org_s;
    longint         delta, y0, y1, frac, acc;
    bit [63:0]      mag, prod, rnd;
    bit             below, hit;
    int unsigned    len, ncol, row;
    interp_result_t res;
    pos_s = pos;
    org_s = origin_q;
    len   = eff_len();
    ncol  = eff_cols();
    row   = 0;
    frac  = 0;
    // t = (position - origin) * inverse_spacing, exact, as sign and Q32.32 magnitude
    delta = longint'(pos_s) - longint'(org_s);
    below = delta < 0;
    mag   = below ? -delta : delta;
    prod  = mag * {32'd0, inv_q};
    if (prod == 0) below = 1'b0;
    if (mode_q == MODE_LINEAR) begin
      // Linear needs rows floor(t) and floor(t)+1 both inside the table
      hit  = !below && len >= 2 && prod[63:32] <= len - 2;
      row  = prod[63:32];
      frac = prod[31:0];
    end else if (below) begin
      // Down to t = -1/2 still rounds up to row 0
      hit = prod <= HALF_Q32 && len >= 1;
    end else begin
      rnd = (prod + HALF_Q32) >> 32;
      hit = rnd < len;
      row = rnd[31:0];
    end
    for (int c = 0; c < ncol; c++) begin
      res.value = '0;
      if (hit) begin
        y0 = grid_samples[c][row];
        if (mode_q == MODE_LINEAR) begin
          // Blend in Q32.32, round to nearest with ties toward plus infinity
          y1  = grid_samples[c][row + 1];
          acc = (y0 <<< 32) + (y1 - y0) * frac + (longint'(1) <<< 31);
          res.value = 16'(acc >>> 32);
        end else begin
          res.value = y0[15:0];
        end
      end
      res.column       = 2'(c);
      res.out_of_range = !hit;
      res.last         = (c + 1 == ncol);
      predicted_samples.push_back(res);
    end
  endfunction

  // Pick a query position: mostly aimed at the table, some beside it, some anywhere.
  function automatic logic [31:0] pick_position();
    int unsigned sel;
    bit [63:0]   tq, dq;
    sel = $urandom_range(0, 99);
    if (sel < 12 || inv_q == 0) return $urandom();
    if (sel < 30) tq = {32'($urandom_range(0, 1)), $urandom()};
    else          tq = {32'($urandom_range(0, eff_len())), $urandom()};
    // Land on grid points and midpoints now and then
    if (sel >= 30 && sel < 45) tq[31:0] = sel[0] ? 32'h8000_0000 : 32'h0;
    dq = tq / {32'd0, inv_q};
    return (sel < 30) ? origin_q - dq[31:0] : origin_q + dq[31:0];
  endfunction

  // Offer one input beat, after a random gap if idle_on; update the shadow when it is taken.
  task automatic send_beat(input cmd_t cmd, input logic [31:0] pos, input logic [9:0] widx,
                           input logic [1:0] wcol, input logic [15:0] wval);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, wval, wcol, widx, pos};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_WRITE) grid_samples[wcol][widx] = wval;
    else interpolate_query(pos);
  endtask

  task automatic put_sample(input logic [9:0] row, input logic [1:0] col,
                            input logic [15:0] val);
    send_beat(CMD_WRITE, $urandom(), row, col, val);
  endtask

  task automatic ask(input logic [31:0] pos);
    send_beat(CMD_QUERY, pos, 10'($urandom()), 2'($urandom()), 16'($urandom()));
  endtask

  // Drop valid, let every predicted beat arrive, then let in-flight writes settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (predicted_samples.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_ORIGIN:     origin_q = data;
      REG_INVERSE_SPACING: inv_q    = data;
      REG_TABLE_LENGTH:    len_q    = data[LEN_W-1:0];
      REG_COLUMNS_USED:    cols_q   = data[NCOL_W-1:0];
      REG_INTERP_MODE:     mode_q   = interp_mode_t'(data[0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reprogram every register; unused upper data bits carry noise.
  task automatic set_config(input logic [31:0] origin, input logic [31:0] inv,
                            input logic [LEN_W-1:0] len, input logic [NCOL_W-1:0] cols,
                            input interp_mode_t mode);
    wait_idle();
    write_reg(REG_GRID_ORIGIN, origin);
    write_reg(REG_INVERSE_SPACING, inv);
    write_reg(REG_TABLE_LENGTH, {21'($urandom()), len});
    write_reg(REG_COLUMNS_USED, {29'($urandom()), cols});
    write_reg(REG_INTERP_MODE, {31'($urandom()), mode});
  endtask

  // Write the low rows and the top two rows of every column; in-range queries stay on these.
  task automatic test_table_load();
    for (int c = 0; c < N_COLS; c++) begin
      for (int r = 0; r < LOAD_ROWS; r++)
        put_sample(10'(r), 2'(c), 16'($urandom()));
      // The top two rows serve the far-end checks
      put_sample(10'(DEPTH - 2), 2'(c), 16'($urandom()));
      put_sample(10'(DEPTH - 1), 2'(c), 16'($urandom()));
    end
  endtask

  // Reset registers: origin 0, spacing 1.0, two rows, one column, linear.
  task automatic test_reset_defaults();
    put_sample(10'd0, 2'd0, 16'h8000);
    put_sample(10'd1, 2'd0, 16'h7FFF);
    ask(32'h0000_0000);
    ask(32'h0000_8000);
    ask(32'h0000_FFFF);
    ask(32'h0001_0000);
    ask(32'hFFFF_FFFF);
  endtask

  // Rounding ties of both signs, full-scale swing, top row and both table ends.
  task automatic test_linear_rounding();
    set_config(32'h0003_0000, 32'd65536, 11'd1024, 3'd4, MODE_LINEAR);
    put_sample(10'd0, 2'd0, 16'd0);
    put_sample(10'd1, 2'd0, 16'd1);
    put_sample(10'd0, 2'd1, 16'd0);
    put_sample(10'd1, 2'd1, 16'hFFFF);
    put_sample(10'd0, 2'd2, 16'h7FFF);
    put_sample(10'd1, 2'd2, 16'h8000);
    put_sample(10'd0, 2'd3, 16'd100);
    put_sample(10'd1, 2'd3, 16'd101);
    ask(32'h0003_8000);
    ask(32'h0003_FFFF);
    ask(32'h0401_FFFF);
    ask(32'h0402_0000);
    ask(32'h0002_FFFF);
  endtask

  // Nearest row: the half step below row 0, a tie, the last row and just past it.
  task automatic test_nearest_rounding();
    set_config(32'h0003_0000, 32'd65536, 11'd1024, 3'd2, MODE_NEAREST);
    ask(32'h0002_8000);
    ask(32'h0002_7FFF);
    ask(32'h0003_8000);
    ask(32'h0401_8000);
    ask(32'h0402_8000);
  endtask

  // Register extremes: empty and one-row tables, column clamps, zero and full-scale inverse spacing.
  task automatic test_config_extremes();
    set_config(32'h0, 32'd65536, 11'd0, 3'd0, MODE_NEAREST);
    ask(32'h0);
    set_config(32'h0, 32'd65536, 11'd1, 3'd7, MODE_NEAREST);
    ask(32'h0000_7FFF);
    set_config(32'h0, 32'd65536, 11'd1, 3'd7, MODE_LINEAR);
    ask(32'h0);
    set_config(32'h8000_0000, 32'h0, 11'd2047, 3'd3, MODE_LINEAR);
    ask(32'h7FFF_FFFF);
    ask(32'h8000_0000);
    set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 11'd1024, 3'd4, MODE_NEAREST);
    ask(32'h8000_0000);
    ask(32'h7FFF_FFFF);
    ask(32'h7FFF_FFFE);
  endtask

  // Random phases: fresh registers each phase, then mixed writes and queries.
  task automatic test_random_traffic();
    logic [31:0]       origin, inv;
    logic [LEN_W-1:0]  len;
    logic [NCOL_W-1:0] cols;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 9))
        0:       origin = 32'h8000_0000;
        1:       origin = 32'h7FFF_FFFF;
        2:       origin = $urandom();
        default: origin = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      endcase
      case ($urandom_range(0, 9))
        0:       inv = 32'h0010_0000;
        1:       inv = 32'h0000_1000;
        2:       inv = $urandom_range(32'h0000_0400, 32'h0040_0000);
        3:       inv = $urandom();
        default: inv = 32'h0001_0000;
      endcase
      // Keep in-range rows inside the loaded part of the table
      case ($urandom_range(0, 9))
        0:       len = 11'($urandom_range(0, LOAD_ROWS));
        1:       len = 11'(LOAD_ROWS);
        2:       len = 11'd2;
        default: len = 11'($urandom_range(2, LOAD_ROWS));
      endcase
      cols = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      set_config(origin, inv, len, cols, interp_mode_t'(ph[0]));
      // Every third phase runs with both sides flat out
      idle_on = (ph % 3 != 2);
      for (int k = 0; k < 32; k++) begin
        if ($urandom_range(0, 99) < 15)
          put_sample(10'($urandom()), 2'($urandom()), 16'($urandom()));
        else
          ask(pick_position());
      end
    end
    idle_on = 1'b1;
  endtask

  // Hold the output off while queries keep coming so the block backs up.
  task automatic test_output_hold();
    set_config(32'($urandom_range(0, 32'h00FF_FFFF)), 32'd65536, 11'(LOAD_ROWS), 3'd4,
               MODE_LINEAR);
    idle_on = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (24) ask(pick_position());
    idle_on = 1'b1;
  endtask

  // Result side pacing: a random gap after each beat, or a long hold when requested.
  always @(negedge clk) begin
    if (!rst_n || hold_left > 0 || sink_gap > 0) out_tready <= 1'b0;
    else out_tready <= 1'b1;
    if (hold_left > 0) hold_left--;
    else if (sink_gap > 0) sink_gap--;
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    interp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      sink_gap = idle_on ? $urandom_range(0, 9) : 0;
      if (predicted_samples.size() == 0) begin
        $error("unexpected result beat: value %0d column %0d",
               $signed(out_tdata[15:0]), out_tdata[17:16]);
        errors++;
      end else begin
        want = predicted_samples.pop_front();
        if (out_tdata[15:0] !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value),
                 $signed(out_tdata[15:0]));
          errors++;
        end
        if (out_tdata[17:16] !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, out_tdata[17:16]);
          errors++;
        end
        if (out_tuser[0] !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range, out_tuser[0]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Hang detector: too long with no beat anywhere ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (any_beat) quiet = 0;
      else quiet++;
    end
    $display("tb_uniform_grid_table_interpolator: errors");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_WRITE;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_ORIGIN;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_table_load();
    test_reset_defaults();
    test_linear_rounding();
    test_nearest_rounding();
    test_config_extremes();
    test_random_traffic();
    test_output_hold();
    wait_idle();

    if (errors == 0) $display("tb_uniform_grid_table_interpolator: clean");
    else $display("tb_uniform_grid_table_interpolator: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ugti_pkg.sv
rtl/uniform_grid_table_interpolator.sv
tb/tb_uniform_grid_table_interpolator.sv
